// ----- src/lsgc_pkg.sv -----
// Shared types, constants and the gap threshold table of the lidar scan
// gap clustering block. No dependencies.
package lsgc_pkg;

  localparam int unsigned COORD_W  = 20;
  localparam int unsigned RANGE_W  = 16;
  localparam int unsigned CL_W     = 10;
  localparam int unsigned SPAN_W   = 10;
  localparam int unsigned THR_SQ_W = 21;
  localparam int unsigned D2_W     = 2 * (COORD_W + 1) + 1;

  localparam logic [SPAN_W-1:0] SPAN_RESET = 10'd5;

  localparam int unsigned QDEPTH  = 8;
  localparam int unsigned QPTR_W  = 3;
  localparam int unsigned QCNT_W  = 4;
  localparam int unsigned NRES    = 3;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic        [RANGE_W-1:0] rng;
    logic                      scan_end;
  } point_t;

  typedef struct packed {
    logic [CL_W-1:0] cl_start;
    logic [CL_W-1:0] cl_end;
    logic            wrapped;
    logic            last;
  } res_t;

  // Squared gap threshold in mm^2, picked by range in mm.
  function automatic logic [THR_SQ_W-1:0] thr_sq(input logic [RANGE_W-1:0] r);
    logic [THR_SQ_W-1:0] t;
    if (r <= 16'd300)       t = 21'd400;
    else if (r <= 16'd500)  t = 21'd2500;
    else if (r <= 16'd800)  t = 21'd12100;
    else if (r <= 16'd1000) t = 21'd28900;
    else if (r <= 16'd2000) t = 21'd360000;
    else if (r <= 16'd3000) t = 21'd490000;
    else if (r <= 16'd4000) t = 21'd722500;
    else if (r <= 16'd5000) t = 21'd810000;
    else if (r <= 16'd6000) t = 21'd1000000;
    else                    t = 21'd1210000;
    return t;
  endfunction

endpackage

// ----- src/lsgc_gap.sv -----
// Gap test between two points: squared distance against the squared,
// range-indexed threshold. Depends on lsgc_pkg.
module lsgc_gap (
  input  logic signed [lsgc_pkg::COORD_W-1:0] ax_i,
  input  logic signed [lsgc_pkg::COORD_W-1:0] ay_i,
  input  logic signed [lsgc_pkg::COORD_W-1:0] bx_i,
  input  logic signed [lsgc_pkg::COORD_W-1:0] by_i,
  input  logic        [lsgc_pkg::RANGE_W-1:0] rng_i,
  output logic                                gap_o
);

  logic signed [lsgc_pkg::COORD_W:0]       dx, dy;
  logic signed [2*lsgc_pkg::COORD_W+1:0]   dx2, dy2;
  logic        [lsgc_pkg::D2_W-1:0]        d2;

  assign dx  = $signed({ax_i[lsgc_pkg::COORD_W-1], ax_i})
             - $signed({bx_i[lsgc_pkg::COORD_W-1], bx_i});
  assign dy  = $signed({ay_i[lsgc_pkg::COORD_W-1], ay_i})
             - $signed({by_i[lsgc_pkg::COORD_W-1], by_i});
  assign dx2 = dx * dx;
  assign dy2 = dy * dy;
  assign d2  = {1'b0, dx2} + {1'b0, dy2};
  assign gap_o = d2 > lsgc_pkg::D2_W'(lsgc_pkg::thr_sq(rng_i));

endmodule

// ----- src/lsgc_core.sv -----
// Per-point cluster bookkeeping: scan state, both gap tests and up to
// three results per point. Depends on lsgc_pkg and lsgc_gap.
module lsgc_core #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  lsgc_pkg::point_t              pt_i,
  input  logic [lsgc_pkg::SPAN_W-1:0]   span_i,
  output lsgc_pkg::res_t                res_o [lsgc_pkg::NRES],
  output logic [lsgc_pkg::NRES-1:0]     res_vld_o
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CMP_W = (IDX_W > lsgc_pkg::SPAN_W) ? IDX_W : lsgc_pkg::SPAN_W;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] os_q, hs_q, he_q;
  logic             hv_q, hz_q;
  logic signed [lsgc_pkg::COORD_W-1:0] px_q, py_q, fx_q, fy_q, fx, fy;
  logic [lsgc_pkg::RANGE_W-1:0] pr_q;

  logic             last, gap_prev, gap_last, ok0, ok1;
  logic [IDX_W-1:0] idx_m1, os_a, hs_a, he_a, os_b, hs_b, he_b;
  logic             hv_a, hz_a, hv_b, hz_b;
  logic [lsgc_pkg::NRES-1:0] v;

  assign idx_m1 = idx_q - IDX_W'(1);
  assign last   = pt_i.scan_end || (idx_q >= IDX_W'(MAX_POINTS - 1));
  assign fx     = (idx_q == '0) ? pt_i.x : fx_q;
  assign fy     = (idx_q == '0) ? pt_i.y : fy_q;

  lsgc_gap u_gap_prev (
    .ax_i (px_q), .ay_i (py_q), .bx_i (pt_i.x), .by_i (pt_i.y),
    .rng_i(pr_q), .gap_o(gap_prev)
  );

  lsgc_gap u_gap_last (
    .ax_i (pt_i.x), .ay_i (pt_i.y), .bx_i (fx), .by_i (fy),
    .rng_i(pt_i.rng), .gap_o(gap_last)
  );

  assign ok0 = CMP_W'(idx_m1 - os_q) >= CMP_W'(span_i);
  assign ok1 = CMP_W'(idx_q - os_a) >= CMP_W'(span_i);

  always_comb begin
    os_a = os_q;
    hs_a = hs_q;
    he_a = he_q;
    hv_a = hv_q;
    hz_a = hz_q;
    v    = '0;
    if (idx_q == '0) begin
      os_a = '0;
      hv_a = 1'b0;
      hz_a = 1'b0;
    end else if (gap_prev) begin
      if (ok0) begin
        if (os_q == '0 && !hv_q) begin
          hv_a = 1'b1;
          hz_a = 1'b1;
          hs_a = '0;
          he_a = idx_m1;
        end else begin
          v[0] = 1'b1;
        end
      end
      os_a = idx_q;
    end

    os_b = os_a;
    hs_b = hs_a;
    he_b = he_a;
    hv_b = hv_a;
    hz_b = hz_a;
    if (last) begin
      if (gap_last) begin
        if (ok1) begin
          if (os_a == '0 && !hv_a) begin
            hv_b = 1'b1;
            hz_b = 1'b1;
            hs_b = '0;
            he_b = idx_q;
          end else begin
            v[1] = 1'b1;
          end
        end
      end else if (hv_a && hz_a) begin
        hs_b = os_a;
        hz_b = 1'b0;
      end
      v[2] = hv_b;
    end

    res_o[0].cl_start = lsgc_pkg::CL_W'(os_q);
    res_o[0].cl_end   = lsgc_pkg::CL_W'(idx_m1);
    res_o[0].wrapped  = 1'b0;
    res_o[0].last     = last && !v[1] && !v[2];
    res_o[1].cl_start = lsgc_pkg::CL_W'(os_a);
    res_o[1].cl_end   = lsgc_pkg::CL_W'(idx_q);
    res_o[1].wrapped  = 1'b0;
    res_o[1].last     = !v[2];
    res_o[2].cl_start = lsgc_pkg::CL_W'(hs_b);
    res_o[2].cl_end   = lsgc_pkg::CL_W'(he_b);
    res_o[2].wrapped  = !hz_b;
    res_o[2].last     = 1'b1;

    res_vld_o = adv_i ? v : '0;
    idx_d     = last ? '0 : idx_q + IDX_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      hv_q  <= 1'b0;
      hz_q  <= 1'b0;
    end else if (adv_i) begin
      idx_q <= idx_d;
      hv_q  <= last ? 1'b0 : hv_a;
      hz_q  <= last ? 1'b0 : hz_a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      os_q <= os_b;
      hs_q <= hs_b;
      he_q <= he_b;
      px_q <= pt_i.x;
      py_q <= pt_i.y;
      pr_q <= pt_i.rng;
      fx_q <= fx;
      fy_q <= fy;
    end
  end

endmodule

// ----- src/lsgc_rq.sv -----
// Result queue: takes up to three results per cycle, in slot order, and
// hands out one per transfer. Depends on lsgc_pkg.
module lsgc_rq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lsgc_pkg::res_t             res_i [lsgc_pkg::NRES],
  input  logic [lsgc_pkg::NRES-1:0]  vld_i,
  input  logic                       pop_i,
  output lsgc_pkg::res_t             head_o,
  output logic                       nempty_o,
  output logic                       room_o
);

  lsgc_pkg::res_t mem_q [lsgc_pkg::QDEPTH];
  logic [lsgc_pkg::QPTR_W-1:0] wp_q, rp_q;
  logic [lsgc_pkg::QCNT_W-1:0] cnt_q;
  logic [lsgc_pkg::QPTR_W-1:0] off [lsgc_pkg::NRES];
  logic [lsgc_pkg::QCNT_W-1:0] npush;

  assign off[0] = '0;
  assign off[1] = lsgc_pkg::QPTR_W'(vld_i[0]);
  assign off[2] = lsgc_pkg::QPTR_W'(vld_i[0]) + lsgc_pkg::QPTR_W'(vld_i[1]);
  assign npush  = lsgc_pkg::QCNT_W'(vld_i[0]) + lsgc_pkg::QCNT_W'(vld_i[1])
                + lsgc_pkg::QCNT_W'(vld_i[2]);

  assign head_o   = mem_q[rp_q];
  assign nempty_o = cnt_q != '0;
  assign room_o   = cnt_q <= lsgc_pkg::QCNT_W'(lsgc_pkg::QDEPTH - lsgc_pkg::NRES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + lsgc_pkg::QPTR_W'(npush);
      rp_q  <= rp_q + lsgc_pkg::QPTR_W'(pop_i);
      cnt_q <= cnt_q + npush - lsgc_pkg::QCNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < lsgc_pkg::NRES; j++) begin
      if (vld_i[j]) begin
        mem_q[wp_q + off[j]] <= res_i[j];
      end
    end
  end

endmodule

// ----- src/lidar_scan_gap_clustering.sv -----
// Top level of the lidar scan gap clustering block: input register,
// configuration port, core and result queue. Depends on lsgc_pkg,
// lsgc_core and lsgc_rq.
//
//  channel   dir  payload                                       end marker
//  s_axis    in   tdata: point_x, point_y, point_range          tlast: scan_end
//  m_axis    out  tdata: cluster_start, cluster_end; tuser: wrapped
//                                                               tlast: last_of_scan
//  apb       in   register 0 at 0x0: min_cluster_span [9:0]
//
// One point per cycle; a point's results enter the result queue as it leaves the input
// register. Up to three results per point drain at one per cycle while m_axis_tready is
// high, so the input stalls only while the eight-entry queue has fewer than three free
// slots. Reset empties the queue and starts a new scan at index 0.
module lidar_scan_gap_clustering #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // point_x[19:0], point_y[39:20], point_range[55:40]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // cluster_start[9:0], cluster_end[19:10], zero[23:20]
  output logic        m_axis_tuser,   // wrapped
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                            in_vld_q;
  lsgc_pkg::point_t                in_q;
  logic                            adv, room;
  logic [lsgc_pkg::SPAN_W-1:0]     span_q;
  lsgc_pkg::res_t                  res [lsgc_pkg::NRES];
  logic [lsgc_pkg::NRES-1:0]       res_vld;
  lsgc_pkg::res_t                  head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(span_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= lsgc_pkg::SPAN_RESET;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      span_q <= pwdata[lsgc_pkg::SPAN_W-1:0];
    end
  end

  assign adv           = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.x        <= s_axis_tdata[19:0];
      in_q.y        <= s_axis_tdata[39:20];
      in_q.rng      <= s_axis_tdata[55:40];
      in_q.scan_end <= s_axis_tlast;
    end
  end

  lsgc_core #(
    .MAX_POINTS(MAX_POINTS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .pt_i     (in_q),
    .span_i   (span_q),
    .res_o    (res),
    .res_vld_o(res_vld)
  );

  lsgc_rq u_rq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .vld_i   (res_vld),
    .pop_i   (m_axis_tvalid && m_axis_tready),
    .head_o  (head),
    .nempty_o(m_axis_tvalid),
    .room_o  (room)
  );

  assign m_axis_tdata = {4'b0, head.cl_end, head.cl_start};
  assign m_axis_tuser = head.wrapped;
  assign m_axis_tlast = head.last;

endmodule
